@@ rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the serial frame deframer: configuration
// register indexes, frame kinds and the entry passed from the front end to
// the decode stage.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_HEADER_FIRST   = 3'd0;
	localparam logic [2:0] CFG_HEADER_SECOND  = 3'd1;
	localparam logic [2:0] CFG_CODE_CAN       = 3'd2;
	localparam logic [2:0] CFG_CODE_FLT_CLEAR = 3'd3;
	localparam logic [2:0] CFG_CODE_FLT_SET   = 3'd4;
	localparam logic [2:0] CFG_CODE_BAUD      = 3'd5;
	localparam logic [2:0] CFG_CODE_TIMING    = 3'd6;

	// Register reset values.
	localparam logic [7:0] RST_HEADER_FIRST   = 8'h66;
	localparam logic [7:0] RST_HEADER_SECOND  = 8'hCC;
	localparam logic [7:0] RST_CODE_CAN       = 8'h30;
	localparam logic [7:0] RST_CODE_FLT_CLEAR = 8'h19;
	localparam logic [7:0] RST_CODE_FLT_SET   = 8'h18;
	localparam logic [7:0] RST_CODE_BAUD      = 8'h13;
	localparam logic [7:0] RST_CODE_TIMING    = 8'h15;

	// Frame kinds as reported on frame_kind.
	localparam logic [2:0] KIND_CAN       = 3'd0;
	localparam logic [2:0] KIND_FLT_CLEAR = 3'd1;
	localparam logic [2:0] KIND_FLT_SET   = 3'd2;
	localparam logic [2:0] KIND_BAUD      = 3'd3;
	localparam logic [2:0] KIND_TIMING    = 3'd4;

	// Frame layout: offsets count from the first header byte.
	localparam logic [4:0] POS_HUNT     = 5'd0;
	localparam logic [4:0] POS_HEADER2  = 5'd1;
	localparam logic [4:0] POS_LEN_HI   = 5'd2;
	localparam logic [4:0] POS_LEN_LO   = 5'd3;
	localparam logic [4:0] POS_CMD      = 5'd4;
	localparam logic [4:0] POS_LAST_CAP = 5'd18;
	localparam logic [4:0] POS_MAX      = 5'd19;

	// Length limits and scaling.
	localparam logic [7:0] MIN_LEN      = 8'd2;
	localparam logic [7:0] MAX_LEN      = 8'd16;
	localparam logic [7:0] CAN_DATA_MAX = 8'd8;
	localparam int unsigned BAUD_UNIT   = 5;

	// Captured bytes cover offsets four to eighteen; the entry carries five on.
	localparam int unsigned CAP_BYTES  = 15;
	localparam int unsigned BODY_BYTES = 14;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] code_can;
		logic [7:0] code_flt_clear;
		logic [7:0] code_flt_set;
		logic [7:0] code_baud;
		logic [7:0] code_timing;
	} cfg_t;

	// body[k] holds frame offset k + 5; bytes not received are zero.
	typedef struct packed {
		logic [2:0]                      kind;
		logic [BODY_BYTES-1:0][7:0]      body;
	} entry_t;

endpackage

@@ rtl/serial_frame_deframer_checksum.sv @@
// ----------------------------------------------------------------------------
// serial_frame_deframer_checksum
// Length-prefixed serial frame deframer with an additive checksum.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while in_stall is low, with no
// gaps needed between frames. The front end hunts for the two header bytes,
// checks the length (2 to 16), keeps a running checksum and captures the frame
// body; on the checksum beat a good frame with a known command goes into a
// two-entry queue. The decode stage fills the output register from the queue
// head, so a result passes the queue and then the output register. Since a
// frame is at least six bytes long, the input stalls only when the output is
// held off long enough for two results to pile up in the queue. The
// configuration port never stalls and should be written while no frame is
// being received.
// ----------------------------------------------------------------------------
module serial_frame_deframer_checksum (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   rx_byte,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [2:0]   frame_kind,
	output logic [7:0]   can_type,
	output logic [31:0]  can_id,
	output logic [3:0]   data_len,
	output logic [63:0]  can_data,
	output logic         reply_ok,
	output logic [7:0]   filter_index,
	output logic [10:0]  baud_kbps,
	output logic [7:0]   seg_one,
	output logic [7:0]   seg_two,
	output logic [15:0]  prescaler
);

	sfd_pkg::cfg_t    cfg_q;
	sfd_pkg::entry_t  push_entry;
	sfd_pkg::entry_t  head;
	logic             push;
	logic             pop;
	logic             empty;
	logic             full;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first   <= sfd_pkg::RST_HEADER_FIRST;
			cfg_q.header_second  <= sfd_pkg::RST_HEADER_SECOND;
			cfg_q.code_can       <= sfd_pkg::RST_CODE_CAN;
			cfg_q.code_flt_clear <= sfd_pkg::RST_CODE_FLT_CLEAR;
			cfg_q.code_flt_set   <= sfd_pkg::RST_CODE_FLT_SET;
			cfg_q.code_baud      <= sfd_pkg::RST_CODE_BAUD;
			cfg_q.code_timing    <= sfd_pkg::RST_CODE_TIMING;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfd_pkg::CFG_HEADER_FIRST:   cfg_q.header_first   <= cfg_data;
				sfd_pkg::CFG_HEADER_SECOND:  cfg_q.header_second  <= cfg_data;
				sfd_pkg::CFG_CODE_CAN:       cfg_q.code_can       <= cfg_data;
				sfd_pkg::CFG_CODE_FLT_CLEAR: cfg_q.code_flt_clear <= cfg_data;
				sfd_pkg::CFG_CODE_FLT_SET:   cfg_q.code_flt_set   <= cfg_data;
				sfd_pkg::CFG_CODE_BAUD:      cfg_q.code_baud      <= cfg_data;
				sfd_pkg::CFG_CODE_TIMING:    cfg_q.code_timing    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.queue_full (full),
		.push       (push),
		.push_entry (push_entry)
	);

	sfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.empty      (empty),
		.full       (full),
		.head       (head)
	);

	sfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_kind   (frame_kind),
		.can_type     (can_type),
		.can_id       (can_id),
		.data_len     (data_len),
		.can_data     (can_data),
		.reply_ok     (reply_ok),
		.filter_index (filter_index),
		.baud_kbps    (baud_kbps),
		.seg_one      (seg_one),
		.seg_two      (seg_two),
		.prescaler    (prescaler)
	);

endmodule

@@ rtl/sfd_front.sv @@
// ----------------------------------------------------------------------------
// sfd_front
// Byte-level front end: header hunt, length check, running checksum and
// byte capture. A good frame with a known command is pushed as one entry.
// ----------------------------------------------------------------------------
module sfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  sfd_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	input  logic              queue_full,
	output logic              push,
	output sfd_pkg::entry_t   push_entry
);

	logic [4:0]                             pos_q;
	logic [4:0]                             left_q;
	logic [7:0]                             sum_q;
	logic [7:0]                             len_hi_q;
	logic [sfd_pkg::CAP_BYTES-1:0][7:0]     cap_q;
	logic [sfd_pkg::CAP_BYTES-1:0][7:0]     cap_next;
	logic                                   accept;
	logic [4:0]                             left_dec;
	logic                                   len_ok;
	logic                                   in_body;
	logic                                   cap_here;
	logic [3:0]                             cap_idx;
	logic                                   kind_hit;
	logic [2:0]                             kind;
	logic [7:0]                             cmd;

	// Stall only when the queue cannot take another frame.
	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;
	assign left_dec = left_q - 5'd1;
	assign in_body  = pos_q >= sfd_pkg::POS_CMD;
	assign cap_here = in_body && (pos_q <= sfd_pkg::POS_LAST_CAP);
	assign cap_idx  = 4'(pos_q - sfd_pkg::POS_CMD);
	assign len_ok   = (len_hi_q == 8'd0) && (rx_byte >= sfd_pkg::MIN_LEN)
		&& (rx_byte <= sfd_pkg::MAX_LEN);

	// Capture array with the current beat merged in.
	always_comb begin
		cap_next = cap_q;
		if (cap_here) begin
			cap_next[cap_idx] = rx_byte;
		end
	end

	// Command classification, first match wins.
	assign cmd = cap_q[0];
	always_comb begin
		kind_hit = 1'b1;
		kind     = sfd_pkg::KIND_CAN;
		if (cmd == cfg.code_can) begin
			kind = sfd_pkg::KIND_CAN;
		end else if (cmd == cfg.code_flt_clear) begin
			kind = sfd_pkg::KIND_FLT_CLEAR;
		end else if (cmd == cfg.code_flt_set) begin
			kind = sfd_pkg::KIND_FLT_SET;
		end else if (cmd == cfg.code_baud) begin
			kind = sfd_pkg::KIND_BAUD;
		end else if (cmd == cfg.code_timing) begin
			kind = sfd_pkg::KIND_TIMING;
		end else begin
			kind_hit = 1'b0;
		end
	end

	// The checksum beat closes the frame.
	assign push = accept && in_body && (left_dec == 5'd0) && (rx_byte == sum_q) && kind_hit;
	assign push_entry.kind = kind;
	assign push_entry.body = cap_next[sfd_pkg::CAP_BYTES-1:1];

	// Frame position, byte count and checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= sfd_pkg::POS_HUNT;
			left_q <= 5'd0;
			sum_q  <= 8'd0;
		end else if (accept) begin
			case (pos_q)
				sfd_pkg::POS_HUNT: begin
					if (rx_byte == cfg.header_first) begin
						pos_q <= sfd_pkg::POS_HEADER2;
					end
					left_q <= 5'd0;
				end
				sfd_pkg::POS_HEADER2: begin
					if (rx_byte == cfg.header_second) begin
						pos_q  <= sfd_pkg::POS_LEN_HI;
						left_q <= 5'd2;
						sum_q  <= 8'd0;
					end else begin
						pos_q  <= sfd_pkg::POS_HUNT;
						left_q <= 5'd0;
					end
				end
				sfd_pkg::POS_LEN_HI: begin
					pos_q  <= sfd_pkg::POS_LEN_LO;
					left_q <= left_dec;
					sum_q  <= sum_q + rx_byte;
				end
				sfd_pkg::POS_LEN_LO: begin
					sum_q <= sum_q + rx_byte;
					if (len_ok) begin
						pos_q  <= sfd_pkg::POS_CMD;
						left_q <= rx_byte[4:0];
					end else begin
						pos_q  <= sfd_pkg::POS_HUNT;
						left_q <= 5'd0;
					end
				end
				default: begin
					left_q <= left_dec;
					if (left_dec != 5'd0) begin
						pos_q <= pos_q + 5'd1;
						sum_q <= sum_q + rx_byte;
					end else begin
						pos_q <= sfd_pkg::POS_HUNT;
					end
				end
			endcase
		end
	end

	// Length high byte and body capture; a new frame starts from zeros.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == sfd_pkg::POS_LEN_HI) begin
				len_hi_q <= rx_byte;
			end
			if (pos_q == sfd_pkg::POS_HEADER2) begin
				cap_q <= '0;
			end else begin
				cap_q <= cap_next;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= sfd_pkg::POS_MAX)
		else $error("frame position ran past the longest frame");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> (accept && pos_q > sfd_pkg::POS_CMD))
		else $error("frame closed before its command byte");
	assert property (@(posedge clk) disable iff (!arst_n) in_body |-> (left_q != 5'd0))
		else $error("byte count empty inside a frame body");

endmodule

@@ rtl/sfd_queue.sv @@
// ----------------------------------------------------------------------------
// sfd_queue
// Short queue of classified frames between the front end and the decoder.
// ----------------------------------------------------------------------------
module sfd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfd_pkg::entry_t   push_entry,
	input  logic              pop,
	output logic              empty,
	output logic              full,
	output sfd_pkg::entry_t   head
);

	sfd_pkg::entry_t                  slot_q [sfd_pkg::QUEUE_DEPTH];
	logic [sfd_pkg::QPTR_W-1:0]       wr_q;
	logic [sfd_pkg::QPTR_W-1:0]       rd_q;
	logic [sfd_pkg::QCNT_W-1:0]       count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == sfd_pkg::QCNT_W'(sfd_pkg::QUEUE_DEPTH));
	assign head  = slot_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sfd_pkg::QCNT_W'(sfd_pkg::QUEUE_DEPTH))
		else $error("queue count above its depth");

endmodule

@@ rtl/sfd_back.sv @@
// ----------------------------------------------------------------------------
// sfd_back
// Decode stage: turns a queued frame into result fields and holds them in
// the output register until the beat is taken.
// ----------------------------------------------------------------------------
module sfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  sfd_pkg::entry_t   head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        frame_kind,
	output logic [7:0]        can_type,
	output logic [31:0]       can_id,
	output logic [3:0]        data_len,
	output logic [63:0]       can_data,
	output logic              reply_ok,
	output logic [7:0]        filter_index,
	output logic [10:0]       baud_kbps,
	output logic [7:0]        seg_one,
	output logic [7:0]        seg_two,
	output logic [15:0]       prescaler
);

	logic                   out_valid_q;
	logic [2:0]             frame_kind_q;
	logic [7:0]             can_type_q;
	logic [31:0]            can_id_q;
	logic [3:0]             data_len_q;
	logic [63:0]            can_data_q;
	logic                   reply_ok_q;
	logic [7:0]             filter_index_q;
	logic [10:0]            baud_kbps_q;
	logic [7:0]             seg_one_q;
	logic [7:0]             seg_two_q;
	logic [15:0]            prescaler_q;
	logic                   load;
	logic [3:0]             dlen;
	logic [63:0]            data;
	logic [7:0]             b5;
	logic [7:0]             b6;
	logic [7:0]             b7;
	logic [7:0]             b8;
	logic [7:0]             b9;
	logic [7:0]             b10;

	// Output register frees up when empty or when its beat is taken.
	assign load = !out_valid_q || !out_stall;
	assign pop  = load && !empty;

	assign b5  = head.body[0];
	assign b6  = head.body[1];
	assign b7  = head.body[2];
	assign b8  = head.body[3];
	assign b9  = head.body[4];
	assign b10 = head.body[5];

	// CAN data length saturates; bytes past it read as zero.
	assign dlen = (b10 > sfd_pkg::CAN_DATA_MAX) ? 4'(sfd_pkg::CAN_DATA_MAX) : b10[3:0];
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			data[8*j +: 8] = (4'(j) < dlen) ? head.body[6+j] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
		end
	end

	// Result fields; fields that do not belong to the kind stay zero.
	always_ff @(posedge clk) begin
		if (pop) begin
			frame_kind_q   <= head.kind;
			can_type_q     <= 8'd0;
			can_id_q       <= 32'd0;
			data_len_q     <= 4'd0;
			can_data_q     <= 64'd0;
			reply_ok_q     <= 1'b0;
			filter_index_q <= 8'd0;
			baud_kbps_q    <= 11'd0;
			seg_one_q      <= 8'd0;
			seg_two_q      <= 8'd0;
			prescaler_q    <= 16'd0;
			case (head.kind)
				sfd_pkg::KIND_CAN: begin
					can_type_q <= b5;
					can_id_q   <= {b6, b7, b8, b9};
					data_len_q <= dlen;
					can_data_q <= data;
				end
				sfd_pkg::KIND_FLT_CLEAR: begin
					reply_ok_q <= (b5 == 8'd0);
				end
				sfd_pkg::KIND_FLT_SET: begin
					reply_ok_q     <= (b5 == 8'd0);
					filter_index_q <= b6;
				end
				sfd_pkg::KIND_BAUD: begin
					baud_kbps_q <= 11'(b6) * 11'(sfd_pkg::BAUD_UNIT);
				end
				sfd_pkg::KIND_TIMING: begin
					seg_one_q   <= b7;
					seg_two_q   <= b8;
					prescaler_q <= {b9, b10};
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_kind   = frame_kind_q;
	assign can_type     = can_type_q;
	assign can_id       = can_id_q;
	assign data_len     = data_len_q;
	assign can_data     = can_data_q;
	assign reply_ok     = reply_ok_q;
	assign filter_index = filter_index_q;
	assign baud_kbps    = baud_kbps_q;
	assign seg_one      = seg_one_q;
	assign seg_two      = seg_two_q;
	assign prescaler    = prescaler_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (frame_kind_q <= sfd_pkg::KIND_TIMING))
		else $error("result carries an unknown frame kind");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (data_len_q <= 4'(sfd_pkg::CAN_DATA_MAX)))
		else $error("data length above eight");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_kind_q != sfd_pkg::KIND_CAN) |-> (can_data_q == 64'd0))
		else $error("CAN data set on a reply frame");

endmodule

@@ dv/tb_serial_frame_deframer_checksum.sv @@
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_checksum
// Self-checking testbench for the serial frame deframer with additive checksum.
// ----------------------------------------------------------------------------
// Bytes are fed one beat at a time through the valid/stall input channel. A
// built-in predictor follows the header hunt, length check, running checksum
// and command decode, and queues the decoded result that each completed frame
// should give. Every result beat on the output channel is checked field by
// field against the oldest queued result. Directed tests cover each frame kind,
// the field extremes and the error cases. Random traffic then runs under
// several register settings, with random idling on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_checksum;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STORE_BYTES  = 32;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned IDLE_LIMIT   = 2000;

	typedef logic [7:0] byte_q_t [$];

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  can_type;
		logic [31:0] can_id;
		logic [3:0]  data_len;
		logic [63:0] can_data;
		logic        reply_ok;
		logic [7:0]  filter_index;
		logic [10:0] baud_kbps;
		logic [7:0]  seg_one;
		logic [7:0]  seg_two;
		logic [15:0] prescaler;
	} decoded_t;

	// Ports of the block; the inputs are at known values from time zero.
	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = sfd_pkg::CFG_HEADER_FIRST;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  frame_kind;
	logic [7:0]  can_type;
	logic [31:0] can_id;
	logic [3:0]  data_len;
	logic [63:0] can_data;
	logic        reply_ok;
	logic [7:0]  filter_index;
	logic [10:0] baud_kbps;
	logic [7:0]  seg_one;
	logic [7:0]  seg_two;
	logic [15:0] prescaler;

	// Predictor state and register copy.
	logic [7:0]    frame_bytes [STORE_BYTES];
	int unsigned   frame_pos;
	int unsigned   frame_left;
	int unsigned   frame_len;
	logic [7:0]    frame_sum;
	sfd_pkg::cfg_t regs;

	// Expected results and bookkeeping.
	decoded_t    decoded_q [$];
	decoded_t    oldest;
	int unsigned mismatches = 0;
	int unsigned rx_beats = 0;
	int unsigned framed_beats = 0;
	int unsigned decoded_checked = 0;
	int unsigned settings_used = 0;
	int unsigned idle_cycles = 0;
	bit          calm = 1'b0;
	bit          hold_out = 1'b0;

	serial_frame_deframer_checksum dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_kind   (frame_kind),
		.can_type     (can_type),
		.can_id       (can_id),
		.data_len     (data_len),
		.can_data     (can_data),
		.reply_ok     (reply_ok),
		.filter_index (filter_index),
		.baud_kbps    (baud_kbps),
		.seg_one      (seg_one),
		.seg_two      (seg_two),
		.prescaler    (prescaler)
	);

	// Free-running clock, 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// A frame offset past the checksum byte reads as zero.
	function automatic logic [7:0] frame_byte_at(input int unsigned k);
		if (k > frame_len + 3 || k >= STORE_BYTES) begin
			return 8'h00;
		end
		return frame_bytes[k];
	endfunction

	// Decode a frame whose checksum matched; returns 0 on an unknown command.
	function automatic bit decode_frame(output decoded_t r);
		logic [7:0]  cmd;
		int unsigned n;
		int unsigned j;
		r = '0;
		cmd = frame_byte_at(4);
		if (cmd == regs.code_can) begin
			n = frame_byte_at(10);
			if (n > sfd_pkg::CAN_DATA_MAX) begin
				n = sfd_pkg::CAN_DATA_MAX;
			end
			r.kind     = sfd_pkg::KIND_CAN;
			r.can_type = frame_byte_at(5);
			r.can_id   = {frame_byte_at(6), frame_byte_at(7), frame_byte_at(8),
				frame_byte_at(9)};
			r.data_len = 4'(n);
			for (j = 0; j < n; j++) begin
				r.can_data[8*j +: 8] = frame_byte_at(11 + j);
			end
		end else if (cmd == regs.code_flt_clear) begin
			r.kind     = sfd_pkg::KIND_FLT_CLEAR;
			r.reply_ok = (frame_byte_at(5) == 8'h00);
		end else if (cmd == regs.code_flt_set) begin
			r.kind         = sfd_pkg::KIND_FLT_SET;
			r.reply_ok     = (frame_byte_at(5) == 8'h00);
			r.filter_index = frame_byte_at(6);
		end else if (cmd == regs.code_baud) begin
			r.kind      = sfd_pkg::KIND_BAUD;
			r.baud_kbps = 11'(frame_byte_at(6) * sfd_pkg::BAUD_UNIT);
		end else if (cmd == regs.code_timing) begin
			r.kind      = sfd_pkg::KIND_TIMING;
			r.seg_one   = frame_byte_at(7);
			r.seg_two   = frame_byte_at(8);
			r.prescaler = {frame_byte_at(9), frame_byte_at(10)};
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advance the deframer by one received byte; returns 1 with a decoded result.
	function automatic bit deframe_byte(input logic [7:0] b, output decoded_t r);
		logic [15:0] len;
		r = '0;
		if (frame_pos >= STORE_BYTES) begin
			frame_pos = sfd_pkg::POS_HUNT;
		end
		// Hunting for the first header byte.
		if (frame_pos == sfd_pkg::POS_HUNT) begin
			if (b == regs.header_first) begin
				frame_bytes[0] = b;
				frame_pos = sfd_pkg::POS_HEADER2;
			end
			frame_left = 0;
			return 1'b0;
		end
		// A mismatched second header byte goes back to hunting, unchecked.
		if (frame_pos == sfd_pkg::POS_HEADER2) begin
			if (b == regs.header_second) begin
				frame_bytes[1] = b;
				frame_pos  = sfd_pkg::POS_LEN_HI;
				frame_left = 2;
				frame_sum  = 8'h00;
			end else begin
				frame_pos  = sfd_pkg::POS_HUNT;
				frame_left = 0;
			end
			return 1'b0;
		end
		// Length bytes, big endian, counted in the checksum.
		if (frame_pos == sfd_pkg::POS_LEN_HI || frame_pos == sfd_pkg::POS_LEN_LO) begin
			frame_bytes[frame_pos] = b;
			frame_pos++;
			frame_sum += b;
			frame_left = (frame_left - 1) & 31;
			if (frame_left == 0) begin
				len = {frame_bytes[2], frame_bytes[3]};
				if (len > sfd_pkg::MAX_LEN || len < sfd_pkg::MIN_LEN) begin
					frame_pos  = sfd_pkg::POS_HUNT;
					frame_left = 0;
				end else begin
					frame_len  = len;
					frame_left = len;
				end
			end
			return 1'b0;
		end
		// Command, payload and finally the checksum byte.
		frame_bytes[frame_pos] = b;
		frame_pos++;
		frame_left = (frame_left - 1) & 31;
		if (frame_left != 0) begin
			frame_sum += b;
			return 1'b0;
		end
		frame_pos = sfd_pkg::POS_HUNT;
		if (b != frame_sum) begin
			return 1'b0;
		end
		return decode_frame(r);
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Send one byte beat, with random idle cycles ahead of it unless calm is set.
	task automatic send_byte(input logic [7:0] b);
		decoded_t r;
		if (!calm) begin
			while ($urandom_range(99) < 37) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		rx_beats++;
		if (!(frame_pos == sfd_pkg::POS_HUNT && b != regs.header_first)) begin
			framed_beats++;
		end
		if (deframe_byte(b, r)) begin
			decoded_q.push_back(r);
		end
	endtask

	// Send a whole frame; the length covers command, payload and checksum.
	task automatic send_frame(input logic [7:0] cmd, input byte_q_t pay, input bit bad_sum);
		logic [15:0] len;
		logic [7:0]  sum;
		int unsigned i;
		len = 16'(pay.size() + 2);
		sum = len[15:8] + len[7:0] + cmd;
		for (i = 0; i < pay.size(); i++) begin
			sum += pay[i];
		end
		if (bad_sum) begin
			sum ^= 8'($urandom_range(1, 255));
		end
		send_byte(regs.header_first);
		send_byte(regs.header_second);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(cmd);
		for (i = 0; i < pay.size(); i++) begin
			send_byte(pay[i]);
		end
		send_byte(sum);
	endtask

	task automatic send_bad_length(input logic [15:0] len);
		send_byte(regs.header_first);
		send_byte(regs.header_second);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// Bring the deframer back to hunting, hold the sender off and let all results drain.
	task automatic settle();
		while (frame_pos != sfd_pkg::POS_HUNT) begin
			send_byte(frame_pos == sfd_pkg::POS_HEADER2 ? ~regs.header_second
				: ~regs.header_first);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			sfd_pkg::CFG_HEADER_FIRST:   regs.header_first   = val;
			sfd_pkg::CFG_HEADER_SECOND:  regs.header_second  = val;
			sfd_pkg::CFG_CODE_CAN:       regs.code_can       = val;
			sfd_pkg::CFG_CODE_FLT_CLEAR: regs.code_flt_clear = val;
			sfd_pkg::CFG_CODE_FLT_SET:   regs.code_flt_set   = val;
			sfd_pkg::CFG_CODE_BAUD:      regs.code_baud      = val;
			sfd_pkg::CFG_CODE_TIMING:    regs.code_timing    = val;
			default: ;
		endcase
	endtask

	// Write all seven registers while the block is idle.
	task automatic load_settings(input logic [7:0] h1, input logic [7:0] h2,
			input logic [7:0] c_can, input logic [7:0] c_clr, input logic [7:0] c_set,
			input logic [7:0] c_baud, input logic [7:0] c_tim);
		settle();
		write_reg(sfd_pkg::CFG_HEADER_FIRST, h1);
		write_reg(sfd_pkg::CFG_HEADER_SECOND, h2);
		write_reg(sfd_pkg::CFG_CODE_CAN, c_can);
		write_reg(sfd_pkg::CFG_CODE_FLT_CLEAR, c_clr);
		write_reg(sfd_pkg::CFG_CODE_FLT_SET, c_set);
		write_reg(sfd_pkg::CFG_CODE_BAUD, c_baud);
		write_reg(sfd_pkg::CFG_CODE_TIMING, c_tim);
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [7:0] pick_command();
		case ($urandom_range(5))
			0: return regs.code_can;
			1: return regs.code_flt_clear;
			2: return regs.code_flt_set;
			3: return regs.code_baud;
			4: return regs.code_timing;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [15:0] pick_bad_length();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'($urandom_range(17, 255));
			default: return {8'($urandom_range(1, 255)), 8'($urandom_range(255))};
		endcase
	endfunction

	// One random unit: mostly well-formed frames, some noise and broken frames.
	task automatic send_random_unit();
		int unsigned pick;
		int unsigned n;
		int unsigned i;
		logic [7:0]  cmd;
		logic [7:0]  b;
		byte_q_t     pay;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
		end else if (pick < 13) begin
			send_bad_length(pick_bad_length());
		end else if (pick < 18) begin
			// Broken header, sometimes with the first header byte repeated.
			b = $urandom_range(1) ? regs.header_first : 8'($urandom_range(255));
			if (b == regs.header_second) begin
				b = ~regs.header_second;
			end
			send_byte(regs.header_first);
			send_byte(b);
		end else begin
			cmd = pick_command();
			n = $urandom_range(0, 14);
			if (cmd == regs.code_can && $urandom_range(3) != 0) begin
				n = $urandom_range(6, 14);
			end
			for (i = 0; i < n; i++) begin
				pay.push_back(8'($urandom_range(255)));
			end
			send_frame(cmd, pay, $urandom_range(9) == 0);
		end
	endtask

	// Every frame kind under the reset settings, with field extremes.
	task automatic test_frame_kinds();
		byte_q_t pay;
		byte_q_t none;
		// Longest CAN frame, all eight data bytes present.
		pay = {8'h01, 8'h12, 8'h34, 8'h56, 8'h78, 8'h08,
			8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88};
		send_frame(regs.code_can, pay, 1'b0);
		// Data count above eight saturates; all fields at their maximum.
		pay = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame(regs.code_can, pay, 1'b0);
		// Shortest CAN frame: the type byte is the checksum, the rest reads zero.
		send_frame(regs.code_can, none, 1'b0);
		// CAN frame ending before its data bytes are all in.
		pay = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'hA5, 8'h5A, 8'hC3};
		send_frame(regs.code_can, pay, 1'b0);
		// Filter replies with good and bad status.
		pay = {8'h00};
		send_frame(regs.code_flt_clear, pay, 1'b0);
		pay = {8'h80};
		send_frame(regs.code_flt_clear, pay, 1'b0);
		pay = {8'hFF, 8'h00};
		send_frame(regs.code_flt_set, pay, 1'b0);
		// Largest baud byte.
		pay = {8'h5A, 8'hFF};
		send_frame(regs.code_baud, pay, 1'b0);
		// Full timing reply, then one cut short by its checksum.
		pay = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame(regs.code_timing, pay, 1'b0);
		pay = {8'hAA, 8'h01, 8'h80};
		send_frame(regs.code_timing, pay, 1'b0);
		settle();
	endtask

	// Checksum errors, unknown commands, bad lengths and header mismatches.
	task automatic test_frame_errors();
		byte_q_t pay;
		pay = {8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h02, 8'hAB, 8'hCD};
		send_frame(regs.code_can, pay, 1'b1);
		send_frame(8'h00, pay, 1'b0);
		send_bad_length(16'h0000);
		send_bad_length(16'h0001);
		send_bad_length(16'h0011);
		send_bad_length(16'hFFFF);
		pay = {8'h00, 8'h30};
		send_frame(regs.code_baud, pay, 1'b0);
		// First header byte twice: the second one is not taken as a new start.
		send_byte(regs.header_first);
		send_frame(regs.code_baud, pay, 1'b0);
		// A broken header followed at once by a good frame.
		send_byte(regs.header_first);
		send_byte(8'h00);
		send_frame(regs.code_baud, pay, 1'b0);
		settle();
	endtask

	// Moved header and command codes, then colliding codes.
	task automatic test_code_registers();
		byte_q_t pay;
		pay = {8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77};
		load_settings(8'hA5, 8'h5A, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05);
		send_frame(8'h01, pay, 1'b0);
		send_frame(8'h02, pay, 1'b0);
		send_frame(8'h03, pay, 1'b0);
		send_frame(8'h04, pay, 1'b0);
		send_frame(8'h05, pay, 1'b0);
		// The first matching code wins.
		load_settings(sfd_pkg::RST_HEADER_FIRST, sfd_pkg::RST_HEADER_SECOND,
			8'h42, 8'h42, 8'h42, 8'h42, 8'h42);
		send_frame(8'h42, pay, 1'b0);
		load_settings(sfd_pkg::RST_HEADER_FIRST, sfd_pkg::RST_HEADER_SECOND,
			8'h00, 8'h42, 8'h42, 8'h42, 8'h42);
		send_frame(8'h42, pay, 1'b0);
		load_settings(sfd_pkg::RST_HEADER_FIRST, sfd_pkg::RST_HEADER_SECOND,
			8'h00, 8'h01, 8'h02, 8'h42, 8'h42);
		send_frame(8'h42, pay, 1'b0);
		settle();
	endtask

	// Frames back to back with no idling on either side.
	task automatic test_back_to_back();
		calm = 1'b1;
		repeat (30) send_random_unit();
		calm = 1'b0;
		settle();
	endtask

	// Hold the output off so results pile up and the input stalls.
	task automatic test_output_backpressure();
		byte_q_t pay;
		int unsigned k;
		calm = 1'b1;
		hold_out = 1'b1;
		fork
			begin
				for (k = 0; k < 8; k++) begin
					pay = {8'h00, 8'(k * 31)};
					send_frame(regs.code_baud, pay, 1'b0);
				end
			end
			begin
				repeat (100) @(posedge clk);
				hold_out = 1'b0;
			end
		join
		calm = 1'b0;
		settle();
	endtask

	// Random traffic under reset, all-zero, all-one, random and colliding settings.
	task automatic test_random_traffic();
		int unsigned phase;
		int unsigned goal;
		logic [7:0]  c;
		for (phase = 0; phase < 5; phase++) begin
			c = 8'($urandom_range(254));
			case (phase)
				0: load_settings(sfd_pkg::RST_HEADER_FIRST, sfd_pkg::RST_HEADER_SECOND,
					sfd_pkg::RST_CODE_CAN, sfd_pkg::RST_CODE_FLT_CLEAR,
					sfd_pkg::RST_CODE_FLT_SET, sfd_pkg::RST_CODE_BAUD,
					sfd_pkg::RST_CODE_TIMING);
				1: load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				2: load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				3: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
				default: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					c + 8'($urandom_range(1)), c + 8'($urandom_range(1)),
					c + 8'($urandom_range(1)), c + 8'($urandom_range(1)),
					c + 8'($urandom_range(1)));
			endcase
			goal = framed_beats + 100;
			while (framed_beats < goal) begin
				send_random_unit();
			end
		end
		settle();
	endtask

	// Receiver: random stalls, none while calm, all while the output is held.
	always @(posedge clk) begin
		out_stall <= hold_out ? 1'b1 : (calm ? 1'b0 : ($urandom_range(99) < 37));
	end

	// Compare each result beat with the oldest expected result.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("result beat with no frame result expected");
			end else begin
				oldest = decoded_q.pop_front();
				check_field("frame_kind", 64'(frame_kind), 64'(oldest.kind));
				check_field("can_type", 64'(can_type), 64'(oldest.can_type));
				check_field("can_id", 64'(can_id), 64'(oldest.can_id));
				check_field("data_len", 64'(data_len), 64'(oldest.data_len));
				check_field("can_data", can_data, oldest.can_data);
				check_field("reply_ok", 64'(reply_ok), 64'(oldest.reply_ok));
				check_field("filter_index", 64'(filter_index), 64'(oldest.filter_index));
				check_field("baud_kbps", 64'(baud_kbps), 64'(oldest.baud_kbps));
				check_field("seg_one", 64'(seg_one), 64'(oldest.seg_one));
				check_field("seg_two", 64'(seg_two), 64'(oldest.seg_two));
				check_field("prescaler", 64'(prescaler), 64'(oldest.prescaler));
				decoded_checked++;
			end
		end
	end

	// Watchdog: end the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("tb_serial_frame_deframer_checksum failed");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		regs = '{sfd_pkg::RST_HEADER_FIRST, sfd_pkg::RST_HEADER_SECOND,
			sfd_pkg::RST_CODE_CAN, sfd_pkg::RST_CODE_FLT_CLEAR,
			sfd_pkg::RST_CODE_FLT_SET, sfd_pkg::RST_CODE_BAUD,
			sfd_pkg::RST_CODE_TIMING};
		foreach (frame_bytes[i]) begin
			frame_bytes[i] = 8'h00;
		end
		frame_pos  = sfd_pkg::POS_HUNT;
		frame_left = 0;
		frame_len  = 0;
		frame_sum  = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_kinds();
		test_frame_errors();
		test_back_to_back();
		test_output_backpressure();
		test_code_registers();
		test_random_traffic();

		$display("Run covered %0d byte beats (%0d inside frames) and %0d decoded results,",
			rx_beats, framed_beats, decoded_checked);
		$display("under %0d register settings beyond reset, with %0d mismatches.",
			settings_used, mismatches);
		if (mismatches == 0) begin
			$display("tb_serial_frame_deframer_checksum passed");
		end else begin
			$display("tb_serial_frame_deframer_checksum failed");
		end
		$finish;
	end

endmodule

@@ serial_frame_deframer_checksum.f @@
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/serial_frame_deframer_checksum.sv
dv/tb_serial_frame_deframer_checksum.sv
